@@ sv/frls_pkg.sv @@
`timescale 1ns / 1ps

package frls_pkg;

  // Page geometry
  localparam int PAGE_BYTES     = 4096;
  localparam int MAX_DATA_BYTES = 256;
  localparam int POS_W          = $clog2(PAGE_BYTES) + 1;
  localparam int OFF_W          = 12;
  localparam int LEFT_W         = $clog2(MAX_DATA_BYTES) + 1;
  localparam int SUM_W          = ((POS_W > 17) ? POS_W : 17) + 2;

  // Record layout
  localparam int HDR_LEN   = 8;
  localparam int CHECK_LEN = 4;
  localparam int MIN_REC   = 12;

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] ERASED_MAGIC = 32'hFFFFFFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC       = 2'd0;
  localparam logic [1:0] CFG_CUR_VERSION = 2'd1;
  localparam logic [1:0] CFG_CUR_SIZE    = 2'd2;
  localparam logic [1:0] CFG_FIRST_SIZE  = 2'd3;

  // Walk phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_CHECK  = 3'b100
  } phase_t;

  // Round a size up to whole words
  function automatic logic [16:0] pad_words(input logic [15:0] size);
    logic [16:0] sum;
    sum = {1'b0, size} + 17'd3;
    return sum & ~17'd3;
  endfunction

  // One byte of reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ sv/flash_record_log_scanner.sv @@
`timescale 1ns / 1ps

// Flash record log scanner.
// Input channel (in_valid/in_ready): one page byte per transfer, in order from
// offset 0; page_start marks offset 0 and drops any scan in progress.
// Output channel (out_valid/out_ready): one result per page, produced by the
// transfer of the page's last byte and shown in the cycle after it. It gives the
// newest usable record, the append offset or the erase request.
// Throughput is one byte per cycle, but for the hold on a page's last byte below:
// the header check, the byte-wide CRC network and the record rules all sit
// between the walk state registers and the result register.
// While a result waits for out_ready, bytes of the next page are still taken;
// only the last byte of a page is held off until the result register is free.
// After the last byte the scan restarts by itself at offset 0.
// Reset (rst, synchronous) clears the walk, drops any pending result and
// loads the register defaults. Configuration writes (cfg_write, cfg_index,
// cfg_data) are registered; the user makes them only while idle (unchecked).
module flash_record_log_scanner (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // page bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  page_byte,
  input  logic        page_start,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        record_found,
  output logic [11:0] newest_offset,
  output logic [15:0] newest_ver,
  output logic [8:0]  newest_size,
  output logic        needs_rewrite,
  output logic [11:0] append_offset,
  output logic        needs_erase
);

  localparam logic [frls_pkg::POS_W-1:0] LAST_POS =
    frls_pkg::POS_W'(frls_pkg::PAGE_BYTES - 1);

  // Configuration registers
  logic [31:0] record_magic;
  logic [15:0] current_version;
  logic [8:0]  current_size;
  logic [8:0]  first_layout_size;

  // Walk state
  logic [frls_pkg::POS_W-1:0]  byte_position;
  logic [frls_pkg::POS_W-1:0]  record_start;
  frls_pkg::phase_t            scan_phase;
  logic [2:0]                  sub_count;
  logic [63:0]                 header_shift;
  logic [31:0]                 running_crc;
  logic [frls_pkg::LEFT_W-1:0] bytes_left;
  logic [31:0]                 stored_check;
  logic                        walk_stopped;
  logic                        stopped_on_erased;
  logic                        best_valid;
  logic [11:0]                 best_offset;
  logic [15:0]                 best_version;
  logic [8:0]                  best_size;

  // Effective state after an optional page restart
  logic [frls_pkg::POS_W-1:0]  cur_pos, cur_start;
  frls_pkg::phase_t            cur_phase;
  logic [2:0]                  cur_sub;
  logic [63:0]                 cur_hs;
  logic [31:0]                 cur_crc, cur_check;
  logic [frls_pkg::LEFT_W-1:0] cur_left;
  logic                        cur_stopped, cur_erased, cur_bvalid;
  logic [11:0]                 cur_boff;
  logic [15:0]                 cur_bver;
  logic [8:0]                  cur_bsize;

  // Next state
  logic [frls_pkg::POS_W-1:0]  record_start_next;
  frls_pkg::phase_t            scan_phase_next;
  logic [2:0]                  sub_count_next;
  logic [63:0]                 header_shift_next;
  logic [31:0]                 running_crc_next, stored_check_next;
  logic [frls_pkg::LEFT_W-1:0] bytes_left_next;
  logic                        walk_stopped_next, stopped_on_erased_next, best_valid_next;
  logic [11:0]                 best_offset_next;
  logic [15:0]                 best_version_next;
  logic [8:0]                  best_size_next;

  logic [63:0]               hs_new;
  logic [31:0]               hdr_magic;
  logic [15:0]               hdr_size, rec_version, rec_size;
  logic [16:0]               hdr_pad;
  logic [frls_pkg::SUM_W-1:0] hdr_end;
  logic [1:0]                tail_fill;
  logic [31:0]               check_new;
  logic [frls_pkg::POS_W-1:0] following;
  logic                      crc_ok, rules_ok;
  logic                      is_last, accept;
  logic [frls_pkg::SUM_W-1:0] room_end;
  logic                      room;

  assign accept   = in_valid && in_ready;
  assign in_ready = (byte_position != LAST_POS) || !out_valid || out_ready;

  // Restart a page scan when page_start is set
  always_comb begin
    if (page_start) begin
      cur_pos     = '0;
      cur_start   = '0;
      cur_phase   = frls_pkg::PH_HEADER;
      cur_sub     = '0;
      cur_hs      = '0;
      cur_crc     = frls_pkg::CRC_INIT;
      cur_check   = '0;
      cur_left    = '0;
      cur_stopped = 1'b0;
      cur_erased  = 1'b0;
      cur_bvalid  = 1'b0;
      cur_boff    = '0;
      cur_bver    = '0;
      cur_bsize   = '0;
    end else begin
      cur_pos     = byte_position;
      cur_start   = record_start;
      cur_phase   = scan_phase;
      cur_sub     = sub_count;
      cur_hs      = header_shift;
      cur_crc     = running_crc;
      cur_check   = stored_check;
      cur_left    = bytes_left;
      cur_stopped = walk_stopped;
      cur_erased  = stopped_on_erased;
      cur_bvalid  = best_valid;
      cur_boff    = best_offset;
      cur_bver    = best_version;
      cur_bsize   = best_size;
    end
  end

  // Header decode and record rules
  assign hs_new      = {page_byte, cur_hs[63:8]};
  assign hdr_magic   = hs_new[31:0];
  assign hdr_size    = hs_new[63:48];
  assign hdr_pad     = frls_pkg::pad_words(hdr_size);
  assign hdr_end     = frls_pkg::SUM_W'(cur_start) + frls_pkg::SUM_W'(hdr_pad)
                     + frls_pkg::SUM_W'(frls_pkg::HDR_LEN + frls_pkg::CHECK_LEN);
  assign rec_version = cur_hs[47:32];
  assign rec_size    = cur_hs[63:48];
  assign tail_fill   = 2'(~rec_size[1:0] + 2'd1);
  assign check_new   = cur_check | ({24'd0, page_byte} << {cur_sub[1:0], 3'b000});
  assign following   = cur_pos + frls_pkg::POS_W'(1);
  assign crc_ok      = (check_new == ~cur_crc);

  always_comb begin
    if (rec_version == 16'd1) begin
      rules_ok = (rec_size == 16'(first_layout_size));
    end else if (rec_version == current_version) begin
      rules_ok = (rec_size == 16'(current_size));
    end else begin
      rules_ok = (rec_version > current_version) && (rec_size >= 16'(current_size));
    end
  end

  // Walk one byte
  always_comb begin
    record_start_next      = cur_start;
    scan_phase_next        = cur_phase;
    sub_count_next         = cur_sub;
    header_shift_next      = cur_hs;
    running_crc_next       = cur_crc;
    stored_check_next      = cur_check;
    bytes_left_next        = cur_left;
    walk_stopped_next      = cur_stopped;
    stopped_on_erased_next = cur_erased;
    best_valid_next        = cur_bvalid;
    best_offset_next       = cur_boff;
    best_version_next      = cur_bver;
    best_size_next         = cur_bsize;
    if (!cur_stopped) begin
      case (cur_phase)
        frls_pkg::PH_HEADER: begin
          header_shift_next = hs_new;
          sub_count_next    = cur_sub + 3'd1;
          if (cur_sub == 3'd7) begin
            if (hdr_magic == frls_pkg::ERASED_MAGIC) begin
              walk_stopped_next      = 1'b1;
              stopped_on_erased_next = 1'b1;
            end else if (hdr_magic != record_magic || hdr_size == 16'd0 ||
                         hdr_size > 16'(frls_pkg::MAX_DATA_BYTES) ||
                         hdr_end > frls_pkg::SUM_W'(frls_pkg::PAGE_BYTES)) begin
              walk_stopped_next      = 1'b1;
              stopped_on_erased_next = 1'b0;
            end else begin
              scan_phase_next = frls_pkg::PH_DATA;
              bytes_left_next = frls_pkg::LEFT_W'(hdr_pad);
            end
          end
        end
        frls_pkg::PH_DATA: begin
          // filler bytes after the data are skipped by the CRC
          if (cur_left > frls_pkg::LEFT_W'(tail_fill)) begin
            running_crc_next = frls_pkg::crc_byte(cur_crc, page_byte);
          end
          bytes_left_next = cur_left - frls_pkg::LEFT_W'(1);
          if (cur_left == frls_pkg::LEFT_W'(1)) begin
            scan_phase_next = frls_pkg::PH_CHECK;
            sub_count_next  = '0;
          end
        end
        frls_pkg::PH_CHECK: begin
          stored_check_next = check_new;
          sub_count_next    = cur_sub + 3'd1;
          if (cur_sub[1:0] == 2'd3) begin
            if (crc_ok && rules_ok) begin
              best_valid_next   = 1'b1;
              best_offset_next  = cur_start[11:0];
              best_version_next = rec_version;
              best_size_next    = rec_size[8:0];
            end
            // next record starts after this byte
            record_start_next = following;
            scan_phase_next   = frls_pkg::PH_HEADER;
            sub_count_next    = '0;
            header_shift_next = '0;
            running_crc_next  = frls_pkg::CRC_INIT;
            stored_check_next = '0;
            bytes_left_next   = '0;
            if ((frls_pkg::SUM_W'(following) + frls_pkg::SUM_W'(frls_pkg::MIN_REC)) >
                frls_pkg::SUM_W'(frls_pkg::PAGE_BYTES)) begin
              walk_stopped_next      = 1'b1;
              stopped_on_erased_next = 1'b0;
            end
          end
        end
        default: begin
          scan_phase_next = frls_pkg::PH_HEADER;
        end
      endcase
    end
  end

  // End of page summary
  assign is_last  = (cur_pos == LAST_POS);
  assign room_end = frls_pkg::SUM_W'(record_start_next)
                  + frls_pkg::SUM_W'(frls_pkg::pad_words(16'(current_size)))
                  + frls_pkg::SUM_W'(frls_pkg::HDR_LEN + frls_pkg::CHECK_LEN);
  assign room     = (room_end <= frls_pkg::SUM_W'(frls_pkg::PAGE_BYTES));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      record_magic      <= '0;
      current_version   <= 16'd3;
      current_size      <= 9'd64;
      first_layout_size <= 9'd32;
    end else if (cfg_write) begin
      case (cfg_index)
        frls_pkg::CFG_MAGIC:       record_magic      <= cfg_data;
        frls_pkg::CFG_CUR_VERSION: current_version   <= cfg_data[15:0];
        frls_pkg::CFG_CUR_SIZE:    current_size      <= cfg_data[8:0];
        frls_pkg::CFG_FIRST_SIZE:  first_layout_size <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Walk state registers
  always_ff @(posedge clk) begin
    if (rst || (accept && is_last)) begin
      byte_position     <= '0;
      record_start      <= '0;
      scan_phase        <= frls_pkg::PH_HEADER;
      sub_count         <= '0;
      header_shift      <= '0;
      running_crc       <= frls_pkg::CRC_INIT;
      stored_check      <= '0;
      bytes_left        <= '0;
      walk_stopped      <= 1'b0;
      stopped_on_erased <= 1'b0;
      best_valid        <= 1'b0;
      best_offset       <= '0;
      best_version      <= '0;
      best_size         <= '0;
    end else if (accept) begin
      byte_position     <= following;
      record_start      <= record_start_next;
      scan_phase        <= scan_phase_next;
      sub_count         <= sub_count_next;
      header_shift      <= header_shift_next;
      running_crc       <= running_crc_next;
      stored_check      <= stored_check_next;
      bytes_left        <= bytes_left_next;
      walk_stopped      <= walk_stopped_next;
      stopped_on_erased <= stopped_on_erased_next;
      best_valid        <= best_valid_next;
      best_offset       <= best_offset_next;
      best_version      <= best_version_next;
      best_size         <= best_size_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      record_found   <= best_valid_next;
      newest_offset  <= best_valid_next ? best_offset_next : '0;
      newest_ver     <= best_valid_next ? best_version_next : '0;
      newest_size    <= best_valid_next ? best_size_next : '0;
      needs_rewrite  <= best_valid_next && (best_version_next != current_version);
      if (walk_stopped_next && stopped_on_erased_next && room) begin
        append_offset <= record_start_next[11:0];
        needs_erase   <= 1'b0;
      end else begin
        append_offset <= '0;
        needs_erase   <= 1'b1;
      end
    end
  end

  // Checks
  a_erased_implies_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped_on_erased |-> walk_stopped)
    else $error("erased flag set while walk still running");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (scan_phase == frls_pkg::PH_DATA) |-> (bytes_left != '0))
    else $error("data phase with no bytes left");

  a_best_clear: assert property (@(posedge clk) disable iff (rst)
    !best_valid |-> (best_offset == '0 && best_size == '0 && best_version == '0))
    else $error("best record fields set without a usable record");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> out_valid)
    else $error("last byte of page gave no result");

endmodule
